// ----- rtl/core/kmc_pkg.sv -----
// Package for the k-means clustering block: sizes, action and result codes,
// and the request/response types of the shared divider.
// No dependencies.
package kmc_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 8;
    localparam int SAMPLE_WIDTH = 16;

    localparam int PT_W   = $clog2(MAX_POINTS);      // point index
    localparam int CNT_W  = PT_W + 1;                // point count
    localparam int CL_W   = $clog2(MAX_CLUSTERS);    // cluster index
    localparam int CLC_W  = CL_W + 1;                // cluster count
    localparam int DM_W   = $clog2(MAX_DIMS);        // coordinate index
    localparam int DMC_W  = DM_W + 1;                // coordinate count
    localparam int PT_AW  = PT_W + DM_W;             // point store address
    localparam int CEN_AW = CL_W + DM_W;             // centroid / sum address
    localparam int SUM_W  = 27;
    localparam int SQ_W   = 32;
    localparam int DIST_W = 36;
    localparam int ERR_W  = 48;
    localparam int ITER_W = 8;

    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

    localparam int DIV_NUM_W = SUM_W;
    localparam int DIV_DEN_W = CNT_W;

    typedef enum logic [1:0] {
        ACT_LOAD     = 2'd0,
        ACT_LABEL    = 2'd1,
        ACT_CENTROID = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_LABEL    = 2'd1,
        KIND_CENTROID = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_CLUSTERS  = 2'd0,
        CFG_DIMS      = 2'd1,
        CFG_ITER_LIM  = 2'd2,
        CFG_THRESHOLD = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

// ----- rtl/core/kmeans_clustering.sv -----
// Lloyd k-means clustering. Loads take one coordinate per cycle while o_in_stall is low; a read
// passes through a read state, which stalls the input, before its result is registered. After
// the final coordinate: zero fill of a partial point, stride divide and seeding, then per iteration
// a clear of the sums, the distance pipeline and a divide per coordinate of each non-empty cluster.
// Reset is synchronous and active low; it clears control and resets configuration to defaults, not the stores.
// Depends on kmc_pkg and kmc_div.
module kmeans_clustering
    import kmc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_action,
    input  logic signed [15:0]      i_coord_value,
    input  logic                    i_last_of_set,
    input  logic [9:0]              i_point_index,
    input  logic [3:0]              i_cluster_index,
    input  logic [2:0]              i_dim_index,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_result_kind,
    output logic                    o_success,
    output logic [7:0]              o_iterations_done,
    output logic [47:0]             o_final_error,
    output logic [3:0]              o_label,
    output logic signed [15:0]      o_centroid_value,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [47:0]             i_cfg_data
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'd1,
        S_FILL   = 19'd2,
        S_START  = 19'd4,
        S_DIVS   = 19'd8,
        S_SEED   = 19'd16,
        S_SEEDW  = 19'd32,
        S_CLR    = 19'd64,
        S_DIST   = 19'd128,
        S_DWAIT  = 19'd256,
        S_ACC    = 19'd512,
        S_AWAIT  = 19'd1024,
        S_CMEM   = 19'd2048,
        S_CCHK   = 19'd4096,
        S_CSUM   = 19'd8192,
        S_CDIVST = 19'd16384,
        S_CDIV   = 19'd32768,
        S_EVAL   = 19'd65536,
        S_RDL    = 19'd131072,
        S_RDC    = 19'd262144
    } t_state;

    localparam logic [DM_W-1:0]   DIM_LAST = DM_W'(MAX_DIMS - 1);
    localparam logic [CEN_AW-1:0] CLR_LAST = {CEN_AW{1'b1}};

    t_state r_state;

    // Configuration
    logic [4:0]       r_cfg_k;
    logic [3:0]       r_cfg_d;
    logic [7:0]       r_cfg_lim;
    logic [ERR_W-1:0] r_cfg_thr;

    // Load and clustering control
    logic [CNT_W-1:0] r_ptotal;
    logic [DM_W-1:0]  r_cursor;
    logic             r_closed;
    logic [CNT_W-1:0] r_stride;
    logic [CNT_W-1:0] r_row;
    logic [PT_W-1:0]  r_i;
    logic [CL_W-1:0]  r_sj;
    logic [DM_W-1:0]  r_sc;
    logic [CEN_AW-1:0] r_clr;
    logic [ERR_W-1:0] r_err_now;
    logic [ERR_W-1:0] r_err_before;
    logic [ITER_W-1:0] r_iter;
    logic             r_first;
    logic             r_rd_ok;

    // Seed copy tag
    logic              r_seed_v;
    logic [CEN_AW-1:0] r_seed_addr;

    // Distance pipeline
    logic              r_p1_v, r_p1_last, r_p1_fin;
    logic [CL_W-1:0]   r_p1_j;
    logic              r_p2_v, r_p2_last, r_p2_fin;
    logic [CL_W-1:0]   r_p2_j;
    logic [SQ_W-1:0]   r_sq;
    logic [DIST_W-1:0] r_acc;
    logic [DIST_W-1:0] r_best;
    logic [CL_W-1:0]   r_bestj;
    logic              r_pt_done;

    // Accumulate tags
    logic              r_a_v;
    logic [CEN_AW-1:0] r_a_addr;
    logic              r_m_v;

    // Centroid update
    logic [CNT_W-1:0]  r_mcount;
    logic              r_neg;

    // Output register
    logic              r_ovalid;
    logic [1:0]        r_okind;
    logic              r_osucc;
    logic [7:0]        r_oiter;
    logic [ERR_W-1:0]  r_oerr;
    logic [3:0]        r_olabel;
    logic [15:0]       r_ocen;

    // Memories
    logic [15:0]      r_pt_mem  [MAX_POINTS*MAX_DIMS];
    logic [15:0]      r_cen_mem [MAX_CLUSTERS*MAX_DIMS];
    logic [SUM_W-1:0] r_sum_mem [MAX_CLUSTERS*MAX_DIMS];
    logic [CNT_W-1:0] r_mem_mem [MAX_CLUSTERS];
    logic [CL_W-1:0]  r_lab_mem [MAX_POINTS];
    logic [15:0]      r_pt_rd;
    logic [15:0]      r_cen_rd;
    logic [SUM_W-1:0] r_sum_rd;
    logic [CNT_W-1:0] r_mem_rd;
    logic [CL_W-1:0]  r_lab_rd;

    logic              pt_we;
    logic [PT_AW-1:0]  pt_waddr, pt_raddr;
    logic [15:0]       pt_wdata;
    logic              cen_we;
    logic [CEN_AW-1:0] cen_waddr, cen_raddr;
    logic [15:0]       cen_wdata;
    logic              sum_we;
    logic [CEN_AW-1:0] sum_waddr, sum_raddr;
    logic [SUM_W-1:0]  sum_wdata;
    logic              mem_we;
    logic [CL_W-1:0]   mem_waddr, mem_raddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic              lab_we;
    logic [PT_W-1:0]   lab_raddr;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic             in_acc;
    logic [CLC_W-1:0] k_eff;
    logic [DMC_W-1:0] d_eff;
    logic [CL_W-1:0]  k_last;
    logic [DM_W-1:0]  d_last;
    logic [CNT_W-1:0] base_tot, ld_tot;
    logic [DM_W-1:0]  base_cur, ld_cur;
    logic [DMC_W-1:0] cur1;
    logic             ld_room;
    logic             start_fail;
    logic             last_pt;

    logic signed [16:0] diff;
    logic signed [33:0] sq_full;
    logic [DIST_W-1:0]  acc_sum;
    logic [ERR_W:0]     err_sum;
    logic [ERR_W-1:0]   n_err_now;
    logic [ERR_W-1:0]   chg;
    logic [ITER_W:0]    iter1;
    logic               more;
    logic [SUM_W-1:0]   sum_abs;
    logic [15:0]        quo16;
    logic [15:0]        cen_val;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE) || (r_ovalid && i_out_stall);
    assign o_cfg_ready = 1'b1;

    // Effective counts
    always_comb begin
        if (r_cfg_k == '0)                       k_eff = CLC_W'(1);
        else if (r_cfg_k > 5'(MAX_CLUSTERS))     k_eff = CLC_W'(MAX_CLUSTERS);
        else                                     k_eff = r_cfg_k;
        if (r_cfg_d == '0)                       d_eff = DMC_W'(1);
        else if (r_cfg_d > 4'(MAX_DIMS))         d_eff = DMC_W'(MAX_DIMS);
        else                                     d_eff = r_cfg_d;
        k_last = CL_W'(k_eff - 1'b1);
        d_last = DM_W'(d_eff - 1'b1);
    end

    // Load cursor arithmetic
    always_comb begin
        base_tot = r_closed ? '0 : r_ptotal;
        base_cur = r_closed ? '0 : r_cursor;
        ld_room  = base_tot < CNT_W'(MAX_POINTS);
        cur1     = {1'b0, base_cur} + 1'b1;
        ld_tot   = base_tot;
        ld_cur   = base_cur;
        if (ld_room) begin
            if (cur1 >= d_eff) begin
                ld_tot = base_tot + 1'b1;
                ld_cur = '0;
            end else begin
                ld_cur = cur1[DM_W-1:0];
            end
        end
        start_fail = r_ptotal < CNT_W'(k_eff);
        last_pt    = ({1'b0, r_i} + 1'b1) == r_ptotal;
    end

    // Arithmetic for distance, error and mean
    always_comb begin
        diff      = $signed({r_pt_rd[15], r_pt_rd}) - $signed({r_cen_rd[15], r_cen_rd});
        sq_full   = diff * diff;
        acc_sum   = r_acc + DIST_W'(r_sq);
        err_sum   = {1'b0, r_err_now} + (ERR_W+1)'(r_best);
        n_err_now = err_sum[ERR_W] ? ERR_MAX : err_sum[ERR_W-1:0];
        chg       = (r_err_now >= r_err_before) ? (r_err_now - r_err_before)
                                                : (r_err_before - r_err_now);
        iter1     = {1'b0, r_iter} + 1'b1;
        more      = (r_first || (chg > r_cfg_thr)) && (iter1 < {1'b0, r_cfg_lim});
        sum_abs   = r_sum_rd[SUM_W-1] ? (~r_sum_rd + 1'b1) : r_sum_rd;
        quo16     = div_rsp.quo[15:0];
        cen_val   = r_neg ? (~quo16 + 1'b1) : quo16;
    end

    // Divider requests: stride, then means
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = DIV_NUM_W'(r_ptotal);
        div_req.den   = DIV_DEN_W'(k_eff);
        if (r_state == S_START && !start_fail) begin
            div_req.start = 1'b1;
        end else if (r_state == S_CDIVST) begin
            div_req.start = 1'b1;
            div_req.num   = sum_abs;
            div_req.den   = r_mcount;
        end
    end

    // Memory port steering
    always_comb begin
        pt_we     = 1'b0;
        pt_waddr  = {base_tot[PT_W-1:0], base_cur};
        pt_wdata  = i_coord_value;
        pt_raddr  = {r_i, r_sc};
        cen_raddr = {r_sj, r_sc};
        sum_raddr = {r_bestj, r_sc};
        mem_raddr = r_bestj;
        lab_raddr = i_point_index;
        lab_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                pt_we     = in_acc && (t_action'(i_action) == ACT_LOAD) && ld_room;
                cen_raddr = {i_cluster_index, i_dim_index};
            end
            S_FILL: begin
                pt_we    = 1'b1;
                pt_waddr = {r_ptotal[PT_W-1:0], r_cursor};
                pt_wdata = '0;
            end
            S_SEED:  pt_raddr  = {r_row[PT_W-1:0], r_sc};
            S_ACC:   lab_we    = (r_sc == '0);
            S_CMEM:  mem_raddr = r_sj;
            S_CSUM:  sum_raddr = {r_sj, r_sc};
            default: ;
        endcase

        cen_we    = r_seed_v;
        cen_waddr = r_seed_addr;
        cen_wdata = r_pt_rd;
        if (r_state == S_CDIV && div_rsp.done) begin
            cen_we    = 1'b1;
            cen_waddr = {r_sj, r_sc};
            cen_wdata = cen_val;
        end

        sum_we    = r_a_v;
        sum_waddr = r_a_addr;
        sum_wdata = r_sum_rd + {{(SUM_W-16){r_pt_rd[15]}}, r_pt_rd};
        mem_we    = r_m_v;
        mem_waddr = r_bestj;
        mem_wdata = r_mem_rd + 1'b1;
        if (r_state == S_CLR) begin
            sum_we    = 1'b1;
            sum_waddr = r_clr;
            sum_wdata = '0;
            mem_we    = (r_clr[DM_W-1:0] == '0);
            mem_waddr = r_clr[CEN_AW-1:DM_W];
            mem_wdata = '0;
        end
    end

    // Stores
    always_ff @(posedge i_clk) begin
        if (pt_we) r_pt_mem[pt_waddr] <= pt_wdata;
        r_pt_rd <= r_pt_mem[pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cen_we) r_cen_mem[cen_waddr] <= cen_wdata;
        r_cen_rd <= r_cen_mem[cen_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) r_sum_mem[sum_waddr] <= sum_wdata;
        r_sum_rd <= r_sum_mem[sum_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem_mem[mem_waddr] <= mem_wdata;
        r_mem_rd <= r_mem_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lab_we) r_lab_mem[r_i] <= r_bestj;
        r_lab_rd <= r_lab_mem[lab_raddr];
    end

    kmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Distance pipeline: square, then accumulate and pick the nearest
    always_ff @(posedge i_clk) begin
        r_sq      <= sq_full[SQ_W-1:0];
        r_p2_last <= r_p1_last;
        r_p2_fin  <= r_p1_fin;
        r_p2_j    <= r_p1_j;
        if (r_p2_v) begin
            if (r_p2_last) begin
                r_acc <= '0;
                if (r_p2_j == '0 || acc_sum < r_best) begin
                    r_best  <= acc_sum;
                    r_bestj <= r_p2_j;
                end
            end else begin
                r_acc <= acc_sum;
            end
        end
        if (r_state == S_CLR) r_acc <= '0;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_k      <= 5'd4;
            r_cfg_d      <= 4'd2;
            r_cfg_lim    <= 8'd20;
            r_cfg_thr    <= '0;
            r_ptotal     <= '0;
            r_cursor     <= '0;
            r_closed     <= 1'b0;
            r_err_now    <= '0;
            r_err_before <= ERR_MAX;
            r_iter       <= '0;
            r_first      <= 1'b0;
            r_seed_v     <= 1'b0;
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_pt_done    <= 1'b0;
            r_a_v        <= 1'b0;
            r_m_v        <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            // Configuration transfer
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_CLUSTERS:  r_cfg_k   <= i_cfg_data[4:0];
                    CFG_DIMS:      r_cfg_d   <= i_cfg_data[3:0];
                    CFG_ITER_LIM:  r_cfg_lim <= i_cfg_data[7:0];
                    CFG_THRESHOLD: r_cfg_thr <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once transferred
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;

            // Pipeline tags default to idle
            r_seed_v  <= 1'b0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= r_p1_v;
            r_pt_done <= r_p2_v && r_p2_fin;
            r_a_v     <= 1'b0;
            r_m_v     <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (t_action'(i_action))
                            ACT_LOAD: begin
                                r_ptotal <= ld_tot;
                                r_cursor <= ld_cur;
                                r_closed <= 1'b0;
                                if (i_last_of_set) begin
                                    r_closed <= 1'b1;
                                    if (ld_cur != '0 && ld_tot < CNT_W'(MAX_POINTS))
                                        r_state <= S_FILL;
                                    else
                                        r_state <= S_START;
                                end
                            end
                            ACT_LABEL: begin
                                r_rd_ok <= {1'b0, i_point_index} < r_ptotal;
                                r_state <= S_RDL;
                            end
                            ACT_CENTROID: begin
                                r_rd_ok <= ({1'b0, i_cluster_index} < k_eff)
                                        && ({1'b0, i_dim_index} < d_eff);
                                r_state <= S_RDC;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FILL: begin
                    // Zero the rest of a partial point
                    if (r_cursor == DIM_LAST) begin
                        r_cursor <= '0;
                        r_ptotal <= r_ptotal + 1'b1;
                        r_state  <= S_START;
                    end else begin
                        r_cursor <= r_cursor + 1'b1;
                    end
                end
                S_START: begin
                    r_iter <= '0;
                    if (start_fail) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_STATUS;
                        r_osucc  <= 1'b0;
                        r_oiter  <= '0;
                        r_oerr   <= '0;
                        r_olabel <= '0;
                        r_ocen   <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    if (div_rsp.done) begin
                        r_stride <= div_rsp.quo[CNT_W-1:0];
                        r_sj     <= '0;
                        r_sc     <= '0;
                        r_row    <= '0;
                        r_state  <= S_SEED;
                    end
                end
                S_SEED: begin
                    // Copy seed points into the centroids
                    r_seed_v    <= 1'b1;
                    r_seed_addr <= {r_sj, r_sc};
                    if (r_sc == d_last) begin
                        r_sc  <= '0;
                        r_sj  <= r_sj + 1'b1;
                        r_row <= r_row + r_stride;
                        if (r_sj == k_last) r_state <= S_SEEDW;
                    end else begin
                        r_sc <= r_sc + 1'b1;
                    end
                end
                S_SEEDW: begin
                    r_err_before <= ERR_MAX;
                    r_err_now    <= '0;
                    r_first      <= 1'b1;
                    r_clr        <= '0;
                    r_state      <= S_CLR;
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_LAST) begin
                        r_i     <= '0;
                        r_sj    <= '0;
                        r_sc    <= '0;
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    // Stream one coordinate pair per cycle
                    r_p1_v    <= 1'b1;
                    r_p1_last <= (r_sc == d_last);
                    r_p1_fin  <= (r_sc == d_last) && (r_sj == k_last);
                    r_p1_j    <= r_sj;
                    if (r_sc == d_last) begin
                        r_sc <= '0;
                        r_sj <= r_sj + 1'b1;
                        if (r_sj == k_last) r_state <= S_DWAIT;
                    end else begin
                        r_sc <= r_sc + 1'b1;
                    end
                end
                S_DWAIT: begin
                    if (r_pt_done) begin
                        r_sc    <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    // Add the point into its cluster's sums
                    r_a_v    <= 1'b1;
                    r_a_addr <= {r_bestj, r_sc};
                    if (r_sc == '0) begin
                        r_m_v     <= 1'b1;
                        r_err_now <= n_err_now;
                    end
                    if (r_sc == d_last) begin
                        r_sc <= '0;
                        r_sj <= '0;
                        if (last_pt) begin
                            r_state <= S_AWAIT;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_DIST;
                        end
                    end else begin
                        r_sc <= r_sc + 1'b1;
                    end
                end
                S_AWAIT: r_state <= S_CMEM;
                S_CMEM:  r_state <= S_CCHK;
                S_CCHK: begin
                    r_mcount <= r_mem_rd;
                    if (r_mem_rd == '0) begin
                        if (r_sj == k_last) begin
                            r_state <= S_EVAL;
                        end else begin
                            r_sj    <= r_sj + 1'b1;
                            r_state <= S_CMEM;
                        end
                    end else begin
                        r_sc    <= '0;
                        r_state <= S_CSUM;
                    end
                end
                S_CSUM: r_state <= S_CDIVST;
                S_CDIVST: begin
                    r_neg   <= r_sum_rd[SUM_W-1];
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    if (div_rsp.done) begin
                        if (r_sc == d_last) begin
                            if (r_sj == k_last) begin
                                r_state <= S_EVAL;
                            end else begin
                                r_sj    <= r_sj + 1'b1;
                                r_state <= S_CMEM;
                            end
                        end else begin
                            r_sc    <= r_sc + 1'b1;
                            r_state <= S_CSUM;
                        end
                    end
                end
                S_EVAL: begin
                    r_iter <= iter1[ITER_W-1:0];
                    if (more) begin
                        r_first      <= 1'b0;
                        r_err_before <= r_err_now;
                        r_err_now    <= '0;
                        r_clr        <= '0;
                        r_state      <= S_CLR;
                    end else begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_STATUS;
                        r_osucc  <= 1'b1;
                        r_oiter  <= iter1[ITER_W-1:0];
                        r_oerr   <= r_err_now;
                        r_olabel <= '0;
                        r_ocen   <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                S_RDL: begin
                    r_ovalid <= 1'b1;
                    r_okind  <= KIND_LABEL;
                    r_osucc  <= 1'b0;
                    r_oiter  <= '0;
                    r_oerr   <= '0;
                    r_olabel <= r_rd_ok ? r_lab_rd : '0;
                    r_ocen   <= '0;
                    r_state  <= S_IDLE;
                end
                S_RDC: begin
                    r_ovalid <= 1'b1;
                    r_okind  <= KIND_CENTROID;
                    r_osucc  <= 1'b0;
                    r_oiter  <= '0;
                    r_oerr   <= '0;
                    r_olabel <= '0;
                    r_ocen   <= r_rd_ok ? r_cen_rd : '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_result_kind     = r_okind;
    assign o_success         = r_osucc;
    assign o_iterations_done = r_oiter;
    assign o_final_error     = r_oerr;
    assign o_label           = r_olabel;
    assign o_centroid_value  = r_ocen;

endmodule

// ----- rtl/core/kmc_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on kmc_pkg for widths and the request/response types.
module kmc_div
    import kmc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEPS = DIV_NUM_W;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DIV_NUM_W-1:0] r_nq;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   trial;
    logic                 ge;
    logic [DIV_DEN_W:0]   n_rem;

    // Shift in next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_nq[DIV_NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? (trial - {1'b0, r_den}) : trial;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_nq  <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[DIV_NUM_W-2:0], ge};
            r_rem <= n_rem[DIV_DEN_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_nq;

endmodule
